// ===== rtl/ldpm_pkg.sv =====
// Shared constants, widths and types for the lens distortion point mapper.
`default_nettype none
package ldpm_pkg;

  localparam int COORD_W   = 18;
  localparam int COEF_FRAC = 16;
  localparam int NORM_FRAC = 16;
  localparam int FOCAL_W   = 17;
  localparam int COEF_W    = 20;
  localparam int PIX_FRAC  = 4;
  localparam int CFG_W     = 2 * COORD_W;
  localparam int CFG_IDX_W = 3;

  localparam int DIFF_W = COORD_W + 2;
  localparam int MAG_W  = COORD_W + 1;
  localparam int QW     = NORM_FRAC + 3;
  localparam int NUM_W  = MAG_W + NORM_FRAC;
  localparam int CMP_W  = (MAG_W > FOCAL_W + 3) ? MAG_W : FOCAL_W + 3;
  localparam int XN_W   = QW + 1;

  localparam int R2_W   = 2 * QW + 2 - NORM_FRAC;
  localparam int X2_W   = 2 * QW + 1 - NORM_FRAC;
  localparam int R4_W   = 2 * R2_W - 1 - NORM_FRAC;
  localparam int R6_W   = R4_W + R2_W - 1 - NORM_FRAC;
  localparam int RAD_W  = NORM_FRAC + 26;
  localparam int FULL_W = XN_W + RAD_W;
  localparam int XD_W   = FULL_W - NORM_FRAC + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PP, REG_FX, REG_FY, REG_K1, REG_K2, REG_K3, REG_P1, REG_P2
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0]       cx;
    logic [COORD_W-1:0]       cy;
    logic [FOCAL_W-1:0]       fx;
    logic [FOCAL_W-1:0]       fy;
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] k3;
    logic signed [COEF_W-1:0] p1;
    logic signed [COEF_W-1:0] p2;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/ldpm_norm.sv =====
// Normalizing pipeline for one axis: offset, magnitude and a one-bit-per-stage divider.
`default_nettype none
module ldpm_norm (
  input  var logic                                 clk,
  input  var logic                                 rst_n,
  input  var logic                                 en,
  input  var logic                                 in_vld,
  input  var logic signed [ldpm_pkg::COORD_W-1:0]  coord,
  input  var logic [ldpm_pkg::COORD_W-1:0]         c,
  input  var logic [ldpm_pkg::FOCAL_W-1:0]         f,
  output logic                                     out_vld,
  output logic signed [ldpm_pkg::XN_W-1:0]         xn,
  output logic                                     ovf
);

  localparam int VLEN = ldpm_pkg::QW + 4;
  localparam int QW = ldpm_pkg::QW;
  localparam int NUM_W = ldpm_pkg::NUM_W;

  logic [VLEN-1:0]                        vld_r;
  logic signed [ldpm_pkg::DIFF_W-1:0]     d_r;
  logic [ldpm_pkg::DIFF_W-1:0]            abs_d;
  logic [ldpm_pkg::MAG_W-1:0]             mag_r;
  logic                                   neg_r;
  logic [NUM_W-1:0]                       rem_r [QW+1];
  logic [QW-1:0]                          q_r [QW+1];
  logic                                   sgn_r [QW+1];
  logic                                   ov_r [QW+1];
  logic [NUM_W:0]                         trial [QW];
  logic                                   ov_nxt;
  logic [QW-1:0]                          qv;
  logic signed [ldpm_pkg::XN_W-1:0]       xn_r;
  logic                                   ovf_r;

  always_comb begin
    abs_d  = d_r[ldpm_pkg::DIFF_W-1] ? -d_r : d_r;
    ov_nxt = (ldpm_pkg::CMP_W'(mag_r) >= (ldpm_pkg::CMP_W'(f) << 3));
    for (int j = 0; j < QW; j++) begin
      trial[j] = {1'b0, rem_r[j]} - ((NUM_W + 1)'(f) << (QW - 1 - j));
    end
    qv = ov_r[QW] ? '1 : q_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= $signed({{2{coord[ldpm_pkg::COORD_W-1]}}, coord}) - $signed({2'b00, c});
      mag_r <= abs_d[ldpm_pkg::MAG_W-1:0];
      neg_r <= d_r[ldpm_pkg::DIFF_W-1];
      rem_r[0] <= {mag_r, {ldpm_pkg::NORM_FRAC{1'b0}}};
      q_r[0]   <= '0;
      sgn_r[0] <= neg_r;
      ov_r[0]  <= ov_nxt;
      for (int j = 0; j < QW; j++) begin
        if (trial[j][NUM_W]) begin
          rem_r[j+1] <= rem_r[j];
          q_r[j+1]   <= q_r[j];
        end else begin
          rem_r[j+1] <= trial[j][NUM_W-1:0];
          q_r[j+1]   <= q_r[j] | (QW'(1) << (QW - 1 - j));
        end
        sgn_r[j+1] <= sgn_r[j];
        ov_r[j+1]  <= ov_r[j];
      end
      xn_r  <= sgn_r[QW] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      ovf_r <= ov_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLEN-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[VLEN-1];
  assign xn      = xn_r;
  assign ovf     = ovf_r;

endmodule
`default_nettype wire

// ===== rtl/ldpm_poly.sv =====
// Radial polynomial and tangential terms on the normalized point, ten register stages.
`default_nettype none
module ldpm_poly (
  input  var logic                              clk,
  input  var logic                              rst_n,
  input  var logic                              en,
  input  var logic                              in_vld,
  input  var logic signed [ldpm_pkg::XN_W-1:0]  xn,
  input  var logic signed [ldpm_pkg::XN_W-1:0]  yn,
  input  var logic                              in_flag,
  input  var ldpm_pkg::cfg_t                    cfg,
  output logic                                  out_vld,
  output logic signed [ldpm_pkg::XD_W-1:0]      xd,
  output logic signed [ldpm_pkg::XD_W-1:0]      yd,
  output logic                                  out_flag
);

  localparam int N     = ldpm_pkg::NORM_FRAC;
  localparam int CF    = ldpm_pkg::COEF_FRAC;
  localparam int CW    = ldpm_pkg::COEF_W;
  localparam int XW    = ldpm_pkg::XN_W;
  localparam int R2W   = ldpm_pkg::R2_W;
  localparam int X2W   = ldpm_pkg::X2_W;
  localparam int R4W   = ldpm_pkg::R4_W;
  localparam int R6W   = ldpm_pkg::R6_W;
  localparam int RW    = ldpm_pkg::RAD_W;
  localparam int FW    = ldpm_pkg::FULL_W;
  localparam int XDW   = ldpm_pkg::XD_W;
  localparam int AW    = R2W + 1;
  localparam int TPW   = CW + AW + 2;
  localparam int TW    = TPW - CF;
  localparam int SPL   = R6W / 2;
  localparam int PW    = CW + R6W + 2;
  localparam int RSW   = PW - CF + 1;
  localparam int SPL2  = RW / 2;
  localparam int NST   = 10;
  localparam logic signed [RSW-1:0] RAD_ONE = RSW'(1) <<< N;
  localparam logic signed [RSW-1:0] RAD_LIM = RSW'(1) <<< (N + 24);

  logic [NST-1:0] vld_r;
  logic           fl_r [NST];

  logic signed [XW-1:0]        xn_r [8];
  logic signed [XW-1:0]        yn_r [8];
  logic signed [TW-1:0]        tx_r [5];
  logic signed [TW-1:0]        ty_r [5];

  logic signed [2*XW-1:0]      xx_r, yy_r, xyp_r;
  logic signed [2*XW-1:0]      sq_sum;
  logic signed [R2W-1:0]       r2b_r, r2c_r, r2d_r;
  logic signed [X2W-1:0]       x2_r, y2_r, xy_r, xyc_r;
  logic signed [2*R2W-1:0]     r4p_r;
  logic signed [AW-1:0]        axc_r, ayc_r;
  logic signed [R4W-1:0]       r4_r;
  logic signed [CW+R2W-1:0]    k1r2d_r, k1r2e_r, k1r2f_r;
  logic signed [CW+X2W-1:0]    p1xy_r, p2xy_r;
  logic signed [CW+AW-1:0]     p2ax_r, p1ay_r;
  logic signed [R4W+R2W-1:0]   r6p_r;
  logic signed [CW+R4W-1:0]    k2r4_r, k2r4f_r;
  logic signed [TPW-1:0]       tsx, tsy;
  logic signed [R6W-1:0]       r6;
  logic signed [CW+R6W-SPL-1:0] k3h_r;
  logic signed [CW+SPL:0]      k3l_r;
  logic signed [PW-1:0]        poly_r, poly_nxt;
  logic signed [RSW-1:0]       rsum;
  logic signed [RW-1:0]        radial_r, radial_nxt;
  logic                        rclip;
  logic signed [XW+SPL2:0]     mxl_r, myl_r;
  logic signed [XW+RW-SPL2-1:0] mxh_r, myh_r;
  logic signed [FW-1:0]        fullx, fully;
  logic signed [XDW-1:0]       xd_r, yd_r;

  always_comb begin
    sq_sum = xx_r + yy_r;
    tsx = (TPW'(p1xy_r) <<< 1) + TPW'(p2ax_r);
    tsy = TPW'(p1ay_r) + (TPW'(p2xy_r) <<< 1);
    r6  = $signed(r6p_r[N+R6W-1:N]);
    poly_nxt = PW'(k1r2f_r) + PW'(k2r4f_r) + (PW'(k3h_r) <<< SPL) + PW'(k3l_r);
    rsum = RSW'($signed(poly_r[PW-1:CF])) + RAD_ONE;
    rclip = 1'b0;
    if (rsum > RAD_LIM) begin
      radial_nxt = RW'(RAD_LIM);
      rclip      = 1'b1;
    end else if (rsum < -RAD_LIM) begin
      radial_nxt = RW'(-RAD_LIM);
      rclip      = 1'b1;
    end else begin
      radial_nxt = RW'(rsum);
    end
    fullx = (FW'(mxh_r) <<< SPL2) + FW'(mxl_r);
    fully = (FW'(myh_r) <<< SPL2) + FW'(myl_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r  <= xn * xn;
      yy_r  <= yn * yn;
      xyp_r <= xn * yn;
      xn_r[0] <= xn;
      yn_r[0] <= yn;
      for (int i = 1; i < 8; i++) begin
        xn_r[i] <= xn_r[i-1];
        yn_r[i] <= yn_r[i-1];
      end

      r2b_r <= $signed(sq_sum[N+R2W-1:N]);
      x2_r  <= $signed(xx_r[N+X2W-1:N]);
      y2_r  <= $signed(yy_r[N+X2W-1:N]);
      xy_r  <= $signed(xyp_r[N+X2W-1:N]);

      r4p_r <= r2b_r * r2b_r;
      axc_r <= AW'(r2b_r) + (AW'(x2_r) <<< 1);
      ayc_r <= AW'(r2b_r) + (AW'(y2_r) <<< 1);
      r2c_r <= r2b_r;
      xyc_r <= xy_r;

      r4_r    <= $signed(r4p_r[N+R4W-1:N]);
      r2d_r   <= r2c_r;
      k1r2d_r <= cfg.k1 * r2c_r;
      p1xy_r  <= cfg.p1 * xyc_r;
      p2xy_r  <= cfg.p2 * xyc_r;
      p2ax_r  <= cfg.p2 * axc_r;
      p1ay_r  <= cfg.p1 * ayc_r;

      r6p_r   <= r4_r * r2d_r;
      k2r4_r  <= cfg.k2 * r4_r;
      k1r2e_r <= k1r2d_r;
      tx_r[0] <= $signed(tsx[TPW-1:CF]);
      ty_r[0] <= $signed(tsy[TPW-1:CF]);
      for (int i = 1; i < 5; i++) begin
        tx_r[i] <= tx_r[i-1];
        ty_r[i] <= ty_r[i-1];
      end

      k3h_r   <= cfg.k3 * $signed(r6[R6W-1:SPL]);
      k3l_r   <= cfg.k3 * $signed({1'b0, r6[SPL-1:0]});
      k1r2f_r <= k1r2e_r;
      k2r4f_r <= k2r4_r;

      poly_r <= poly_nxt;

      radial_r <= radial_nxt;

      mxl_r <= xn_r[7] * $signed({1'b0, radial_r[SPL2-1:0]});
      myl_r <= yn_r[7] * $signed({1'b0, radial_r[SPL2-1:0]});
      mxh_r <= xn_r[7] * $signed(radial_r[RW-1:SPL2]);
      myh_r <= yn_r[7] * $signed(radial_r[RW-1:SPL2]);

      xd_r <= XDW'($signed(fullx[FW-1:N])) + XDW'(tx_r[4]);
      yd_r <= XDW'($signed(fully[FW-1:N])) + XDW'(ty_r[4]);

      fl_r[0] <= in_flag;
      for (int i = 1; i < NST; i++) begin
        fl_r[i] <= (i == 7) ? (fl_r[i-1] | rclip) : fl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign xd       = xd_r;
  assign yd       = yd_r;
  assign out_flag = fl_r[NST-1];

endmodule
`default_nettype wire

// ===== rtl/ldpm_pix.sv =====
// Scaling of one distorted normalized coordinate back to saturated pixels.
`default_nettype none
module ldpm_pix (
  input  var logic                              clk,
  input  var logic                              rst_n,
  input  var logic                              en,
  input  var logic                              in_vld,
  input  var logic signed [ldpm_pkg::XD_W-1:0]  nd,
  input  var logic [ldpm_pkg::FOCAL_W-1:0]      f,
  input  var logic [ldpm_pkg::COORD_W-1:0]      c,
  input  var logic                              in_flag,
  output logic                                  out_vld,
  output logic [ldpm_pkg::COORD_W-1:0]          pix,
  output logic                                  clip
);

  localparam int N    = ldpm_pkg::NORM_FRAC;
  localparam int CRW  = ldpm_pkg::COORD_W;
  localparam int XDW  = ldpm_pkg::XD_W;
  localparam int CLW  = CRW - 3 + N + 2;
  localparam int PRW  = CLW + ldpm_pkg::FOCAL_W + 1;
  localparam int SW   = PRW - N + 1;
  localparam logic signed [XDW-1:0] ND_LIM = XDW'(1) <<< (CRW - 3 + N);
  localparam logic signed [SW-1:0]  PIX_HI = (SW'(1) <<< (CRW - 1)) - SW'(1);
  localparam logic signed [SW-1:0]  PIX_LO = -(SW'(1) <<< (CRW - 1));

  logic [2:0]              vld_r;
  logic [1:0]              fl_r;
  logic signed [CLW-1:0]   ndc_r;
  logic signed [XDW-1:0]   ndc;
  logic signed [PRW-1:0]   prod_r;
  logic signed [SW-1:0]    psum;
  logic [CRW-1:0]          pix_r;
  logic                    clip_r;

  always_comb begin
    if (nd > ND_LIM) begin
      ndc = ND_LIM;
    end else if (nd < -ND_LIM) begin
      ndc = -ND_LIM;
    end else begin
      ndc = nd;
    end
    psum = SW'($signed(prod_r[PRW-1:N])) + SW'($signed({1'b0, c}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ndc_r   <= CLW'(ndc);
      fl_r[0] <= in_flag;
      prod_r  <= ndc_r * $signed({1'b0, f});
      fl_r[1] <= fl_r[0];
      if (psum > PIX_HI) begin
        pix_r  <= PIX_HI[CRW-1:0];
        clip_r <= 1'b1;
      end else if (psum < PIX_LO) begin
        pix_r  <= PIX_LO[CRW-1:0];
        clip_r <= 1'b1;
      end else begin
        pix_r  <= psum[CRW-1:0];
        clip_r <= fl_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign out_vld = vld_r[2];
  assign pix     = pix_r;
  assign clip    = clip_r;

endmodule
`default_nettype wire

// ===== rtl/lens_distortion_point_map_core.sv =====
// Top level of the lens distortion point mapper: registers, handshake and pipeline.
//
//   channel | beat contents                         | flow control
//   in_     | in_ideal_x, in_ideal_y                | in_valid / in_stall
//   out_    | out_warped_x, out_warped_y, clipped   | out_valid / out_stall
//   cfg_    | cfg_index, cfg_data                   | cfg_we, no back pressure
//
// One beat enters per cycle unless the output beat is stalled.
// The pipeline depth is set by the 19-stage restoring divider and the multiplier chain.
// Reset is synchronous and empties the pipeline; registers return to their defaults.
// The whole pipeline holds while the output beat is stalled.
`default_nettype none
module lens_distortion_point_map_core (
  input  var logic                                  clk,
  input  var logic                                  rst_n,
  input  var logic                                  in_valid,
  output logic                                      in_stall,
  input  var logic signed [ldpm_pkg::COORD_W-1:0]   in_ideal_x,
  input  var logic signed [ldpm_pkg::COORD_W-1:0]   in_ideal_y,
  output logic                                      out_valid,
  input  var logic                                  out_stall,
  output logic signed [ldpm_pkg::COORD_W-1:0]       out_warped_x,
  output logic signed [ldpm_pkg::COORD_W-1:0]       out_warped_y,
  output logic                                      out_clipped,
  input  var logic                                  cfg_we,
  input  var logic [ldpm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  var logic [ldpm_pkg::CFG_W-1:0]            cfg_data
);

  localparam logic [ldpm_pkg::FOCAL_W-1:0] FOCAL_ONE =
    ldpm_pkg::FOCAL_W'(1) << ldpm_pkg::PIX_FRAC;

  logic [ldpm_pkg::CFG_W-1:0]          pp_r;
  logic [ldpm_pkg::FOCAL_W-1:0]        fx_r, fy_r;
  logic signed [ldpm_pkg::COEF_W-1:0]  k1_r, k2_r, k3_r, p1_r, p2_r;
  ldpm_pkg::reg_idx_t                  idx;
  ldpm_pkg::cfg_t                      cfg;
  logic                                en;

  logic                                nvx, nvy, nfx, nfy;
  logic signed [ldpm_pkg::XN_W-1:0]    xn, yn;
  logic                                pv, pf;
  logic signed [ldpm_pkg::XD_W-1:0]    xd, yd;
  logic                                pvx, pvy, clx, cly;
  logic [ldpm_pkg::COORD_W-1:0]        wx, wy;

  assign idx = ldpm_pkg::reg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r <= '0;
      fx_r <= FOCAL_ONE;
      fy_r <= FOCAL_ONE;
      k1_r <= '0;
      k2_r <= '0;
      k3_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (cfg_we) begin
      unique case (idx)
        ldpm_pkg::REG_PP: pp_r <= cfg_data;
        ldpm_pkg::REG_FX: fx_r <= cfg_data[ldpm_pkg::FOCAL_W-1:0];
        ldpm_pkg::REG_FY: fy_r <= cfg_data[ldpm_pkg::FOCAL_W-1:0];
        ldpm_pkg::REG_K1: k1_r <= $signed(cfg_data[ldpm_pkg::COEF_W-1:0]);
        ldpm_pkg::REG_K2: k2_r <= $signed(cfg_data[ldpm_pkg::COEF_W-1:0]);
        ldpm_pkg::REG_K3: k3_r <= $signed(cfg_data[ldpm_pkg::COEF_W-1:0]);
        ldpm_pkg::REG_P1: p1_r <= $signed(cfg_data[ldpm_pkg::COEF_W-1:0]);
        ldpm_pkg::REG_P2: p2_r <= $signed(cfg_data[ldpm_pkg::COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Focal lengths below one pixel are treated as one pixel.
  always_comb begin
    cfg.cx = pp_r[ldpm_pkg::COORD_W-1:0];
    cfg.cy = pp_r[ldpm_pkg::CFG_W-1:ldpm_pkg::COORD_W];
    cfg.fx = (fx_r < FOCAL_ONE) ? FOCAL_ONE : fx_r;
    cfg.fy = (fy_r < FOCAL_ONE) ? FOCAL_ONE : fy_r;
    cfg.k1 = k1_r;
    cfg.k2 = k2_r;
    cfg.k3 = k3_r;
    cfg.p1 = p1_r;
    cfg.p2 = p2_r;
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ldpm_norm u_norm_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .coord(in_ideal_x), .c(cfg.cx), .f(cfg.fx),
    .out_vld(nvx), .xn(xn), .ovf(nfx)
  );

  ldpm_norm u_norm_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .coord(in_ideal_y), .c(cfg.cy), .f(cfg.fy),
    .out_vld(nvy), .xn(yn), .ovf(nfy)
  );

  ldpm_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(nvx && nvy),
    .xn(xn), .yn(yn), .in_flag(nfx || nfy), .cfg(cfg),
    .out_vld(pv), .xd(xd), .yd(yd), .out_flag(pf)
  );

  ldpm_pix u_pix_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(pv),
    .nd(xd), .f(cfg.fx), .c(cfg.cx), .in_flag(pf),
    .out_vld(pvx), .pix(wx), .clip(clx)
  );

  ldpm_pix u_pix_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(pv),
    .nd(yd), .f(cfg.fy), .c(cfg.cy), .in_flag(pf),
    .out_vld(pvy), .pix(wy), .clip(cly)
  );

  assign out_valid    = pvx && pvy;
  assign out_warped_x = $signed(wx);
  assign out_warped_y = $signed(wy);
  assign out_clipped  = clx || cly;

  a_norm_align: assert property (@(posedge clk) disable iff (!rst_n) nvx == nvy)
    else $error("normalizer lanes out of step");

  a_pix_align: assert property (@(posedge clk) disable iff (!rst_n) pvx == pvy)
    else $error("pixel lanes out of step");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present right after reset");

endmodule
`default_nettype wire
